/* hw/rtl/bog_pkg.sv */
// ----------------------------------------------------------------------------
// bog_pkg
// shared widths, register codes, reset values and the job record that the
// front end hands to the back end of the bump offset generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bog_pkg;

	// frame limits
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	// field widths
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int ROW_W    = $clog2(MAX_HEIGHT);
	localparam int DIM_W    = 11;
	localparam int GAIN_W   = 4;
	localparam int SAMPLE_W = 8;
	localparam int ADDR_W   = 20;

	// arithmetic widths: scaled slope, displaced coordinate, address product
	localparam int SLOPE_W = SAMPLE_W + GAIN_W + 2;
	localparam int POS_W   = SLOPE_W + 1;
	localparam int PROD_W  = ROW_W + DIM_W;

	// job queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// register port
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_SLOPE_GAIN   = REG_IDX_W'(2);

	localparam logic [DIM_W-1:0]  FRAME_WIDTH_RST  = DIM_W'(320);
	localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST = DIM_W'(240);
	localparam logic [GAIN_W-1:0] SLOPE_GAIN_RST   = GAIN_W'(2);

	// result kinds a sample can cause, in output order
	localparam int KIND_N = 3;
	localparam logic [KIND_N-1:0] KIND_UP   = 3'b001; // pixel one row above
	localparam logic [KIND_N-1:0] KIND_LEFT = 3'b010; // previous pixel, last row
	localparam logic [KIND_N-1:0] KIND_SELF = 3'b100; // frame's final pixel

	// effective frame settings
	typedef struct packed {
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		logic [GAIN_W-1:0] gain;
	} cfg_t;

	// one classified sample with its neighbours
	typedef struct packed {
		logic [COL_W-1:0]    x;
		logic [ROW_W-1:0]    y;
		logic [SAMPLE_W-1:0] sample;
		logic [SAMPLE_W-1:0] prev;
		logic [SAMPLE_W-1:0] above;
		logic [SAMPLE_W-1:0] right;
		logic [KIND_N-1:0]   kinds;
	} job_t;

endpackage

/* hw/rtl/bog_in_if.sv */
// ----------------------------------------------------------------------------
// bog_in_if
// height sample stream, valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bog_in_if import bog_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] height_sample;

	modport source (output valid, output height_sample, input ready);
	modport sink (input valid, input height_sample, output ready);
endinterface

/* hw/rtl/bog_out_if.sv */
// ----------------------------------------------------------------------------
// bog_out_if
// offset result stream, valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bog_out_if import bog_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] pixel_index;
	logic [ADDR_W-1:0] source_offset;
	logic              last_of_run;
	logic              frame_done;

	modport source (output valid, output pixel_index, output source_offset,
		output last_of_run, output frame_done, input ready);
	modport sink (input valid, input pixel_index, input source_offset,
		input last_of_run, input frame_done, output ready);
endinterface

/* hw/rtl/bog_ram.sv */
// ----------------------------------------------------------------------------
// bog_ram
// generic single-write, dual-read ram with registered read-before-write data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bog_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read ports return the old word on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

/* hw/rtl/bog_cfg.sv */
// ----------------------------------------------------------------------------
// bog_cfg
// apb register file for frame size and slope gain, with range saturation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bog_cfg import bog_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output cfg_t               cfg
);

	logic [DIM_W-1:0]     width_q;
	logic [DIM_W-1:0]     height_q;
	logic [GAIN_W-1:0]    gain_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr;

	assign idx = paddr[PADDR_W-1:2];
	assign wr  = psel & penable & pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= FRAME_WIDTH_RST;
			height_q <= FRAME_HEIGHT_RST;
			gain_q   <= SLOPE_GAIN_RST;
		end else if (wr) begin
			case (idx)
				REG_FRAME_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_FRAME_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				REG_SLOPE_GAIN:   gain_q   <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (idx)
			REG_FRAME_WIDTH:  prdata = PDATA_W'(width_q);
			REG_FRAME_HEIGHT: prdata = PDATA_W'(height_q);
			REG_SLOPE_GAIN:   prdata = PDATA_W'(gain_q);
			default:          prdata = '0;
		endcase
	end

	// zero counts as one, oversize saturates to the maximum
	always_comb begin
		if (width_q == '0) begin
			cfg.width = DIM_W'(1);
		end else if (width_q > DIM_W'(MAX_WIDTH)) begin
			cfg.width = DIM_W'(MAX_WIDTH);
		end else begin
			cfg.width = width_q;
		end
		if (height_q == '0) begin
			cfg.height = DIM_W'(1);
		end else if (height_q > DIM_W'(MAX_HEIGHT)) begin
			cfg.height = DIM_W'(MAX_HEIGHT);
		end else begin
			cfg.height = height_q;
		end
		cfg.gain = gain_q;
	end

endmodule

/* hw/rtl/bog_front.sv */
// ----------------------------------------------------------------------------
// bog_front
// accepts height samples, tracks the raster position, keeps the line buffer
// and classifies each sample into the results it resolves
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bog_front import bog_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	bog_in_if.sink samples,
	input  logic   q_full,
	output logic   push,
	output job_t   push_job
);

	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic [SAMPLE_W-1:0] prev_q;
	logic [SAMPLE_W-1:0] row_first_q;

	logic                valid_s1;
	logic [COL_W-1:0]    col_s1;
	logic [ROW_W-1:0]    row_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [SAMPLE_W-1:0] prev_s1;
	logic [SAMPLE_W-1:0] right_fix_s1;
	logic                last_col_s1;
	logic [KIND_N-1:0]   kinds_s1;

	logic                acc;
	logic                s1_busy;
	logic [DIM_W-1:0]    wm1;
	logic [DIM_W-1:0]    hm1;
	logic                last_col;
	logic                last_row;
	logic [SAMPLE_W-1:0] right_fix;
	logic [KIND_N-1:0]   kinds;
	logic [SAMPLE_W-1:0] above_rd;
	logic [SAMPLE_W-1:0] right_rd;

	// beat handshake: stage 1 blocks only when it holds work and the queue is full
	assign s1_busy       = valid_s1 & (kinds_s1 != '0) & q_full;
	assign samples.ready = ~s1_busy;
	assign acc           = samples.valid & samples.ready;

	// position classification
	assign wm1      = cfg.width - DIM_W'(1);
	assign hm1      = cfg.height - DIM_W'(1);
	assign last_col = DIM_W'(col_q) >= wm1;
	assign last_row = DIM_W'(row_q) >= hm1;

	// right neighbour of a row's last pixel wraps to the current row's start
	assign right_fix = (col_q == '0) ? samples.height_sample : row_first_q;

	always_comb begin
		kinds = '0;
		if (row_q != '0) begin
			kinds = kinds | KIND_UP;
		end
		if (last_row && (col_q != '0)) begin
			kinds = kinds | KIND_LEFT;
		end
		if (last_row && last_col) begin
			kinds = kinds | KIND_SELF;
		end
	end

	// raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// previous sample and first sample of the row
	always_ff @(posedge clk) begin
		if (acc) begin
			prev_q <= samples.height_sample;
			if (col_q == '0) begin
				row_first_q <= samples.height_sample;
			end
		end
	end

	// line buffer: old row read at x and x+1 while the new sample lands at x
	bog_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk     (clk),
		.we      (acc),
		.waddr   (col_q),
		.wdata   (samples.height_sample),
		.re      (acc),
		.raddr_a (col_q),
		.raddr_b (col_q + COL_W'(1)),
		.rdata_a (above_rd),
		.rdata_b (right_rd)
	);

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc | s1_busy;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (acc) begin
			col_s1       <= col_q;
			row_s1       <= row_q;
			sample_s1    <= samples.height_sample;
			prev_s1      <= prev_q;
			right_fix_s1 <= right_fix;
			last_col_s1  <= last_col;
			kinds_s1     <= kinds;
		end
	end

	// samples that resolve nothing are dropped here
	assign push = valid_s1 & (kinds_s1 != '0) & ~q_full;

	always_comb begin
		push_job.x      = col_s1;
		push_job.y      = row_s1;
		push_job.sample = sample_s1;
		push_job.prev   = prev_s1;
		push_job.above  = above_rd;
		push_job.right  = last_col_s1 ? right_fix_s1 : right_rd;
		push_job.kinds  = kinds_s1;
	end

endmodule

/* hw/rtl/bog_queue.sv */
// ----------------------------------------------------------------------------
// bog_queue
// short fifo of classified jobs between the front and back ends
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bog_queue import bog_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t head,
	output logic empty
);

	job_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full  = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W + 1)'(1);
				default: ;
			endcase
		end
	end

endmodule

/* hw/rtl/bog_back.sv */
// ----------------------------------------------------------------------------
// bog_back
// expands each job into its results and runs them through the slope,
// clamp and address pipeline, one result per cycle while jobs wait and results is not stalled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bog_back import bog_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  job_t       head,
	input  logic       empty,
	output logic       pop,
	bog_out_if.source  results
);

	logic [KIND_N-1:0] taken_q;

	logic                valid_s1, valid_s2, valid_s3, valid_s4;
	logic [COL_W-1:0]    cx_s1, cx_s2;
	logic [ROW_W-1:0]    cy_s1, cy_s2;
	logic [SAMPLE_W-1:0] a_s1, b_s1, c_s1;
	logic                done_s1, done_s2, done_s3, done_s4;
	logic                last_s1, last_s2, last_s3, last_s4;
	logic signed [SLOPE_W-1:0] dx_s2, dy_s2;
	logic [ADDR_W-1:0]   pix_s2, pix_s3, pix_s4;
	logic [COL_W-1:0]    xc_s3;
	logic [ROW_W-1:0]    yc_s3;
	logic [ADDR_W-1:0]   off_s4;

	logic                adv;
	logic                issue;
	logic [KIND_N-1:0]   pend;
	logic [KIND_N-1:0]   pick;
	logic [KIND_N-1:0]   rest;
	logic [COL_W-1:0]    cx;
	logic [ROW_W-1:0]    cy;
	logic [SAMPLE_W-1:0] a, b, c;
	logic                done;

	logic signed [SAMPLE_W:0]  dxd, dyd;
	logic signed [GAIN_W:0]    gs;
	logic signed [SLOPE_W-1:0] dx, dy;
	logic [PROD_W-1:0]         pix_sum;
	logic signed [POS_W-1:0]   xp, yp;
	logic [DIM_W-1:0]          wm1, hm1;
	logic [COL_W-1:0]          xc;
	logic [ROW_W-1:0]          yc;
	logic [PROD_W-1:0]         off_sum;

	// the whole pipeline moves when the output register is free or taken
	assign adv   = ~valid_s4 | results.ready;
	assign issue = adv & ~empty;

	// lowest pending kind of the head job goes next
	assign pend = head.kinds & ~taken_q;
	assign pick = pend & (~pend + KIND_N'(1));
	assign rest = pend & ~pick;
	assign pop  = issue & (rest == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
		end else if (issue) begin
			taken_q <= (rest == '0) ? '0 : (taken_q | pick);
		end
	end

	// pixel and neighbour selection per kind; zero slopes use equal heights
	always_comb begin
		case (pick)
			KIND_UP: begin
				cx   = head.x;
				cy   = head.y - ROW_W'(1);
				a    = head.above;
				b    = head.right;
				c    = head.sample;
				done = 1'b0;
			end
			KIND_LEFT: begin
				cx   = head.x - COL_W'(1);
				cy   = head.y;
				a    = head.prev;
				b    = head.sample;
				c    = head.prev;
				done = 1'b0;
			end
			KIND_SELF: begin
				cx   = head.x;
				cy   = head.y;
				a    = '0;
				b    = '0;
				c    = '0;
				done = 1'b1;
			end
			default: begin
				cx   = '0;
				cy   = '0;
				a    = '0;
				b    = '0;
				c    = '0;
				done = 1'b0;
			end
		endcase
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// stage 2: scaled slopes and pixel index
	assign dxd     = $signed({1'b0, a_s1}) - $signed({1'b0, b_s1});
	assign dyd     = $signed({1'b0, a_s1}) - $signed({1'b0, c_s1});
	assign gs      = $signed({1'b0, cfg.gain});
	assign dx      = SLOPE_W'(dxd) * SLOPE_W'(gs);
	assign dy      = SLOPE_W'(dyd) * SLOPE_W'(gs);
	assign pix_sum = PROD_W'(cy_s1) * PROD_W'(cfg.width) + PROD_W'(cx_s1);

	// stage 3: displace and clamp into the frame
	assign wm1 = cfg.width - DIM_W'(1);
	assign hm1 = cfg.height - DIM_W'(1);
	assign xp  = $signed(POS_W'(cx_s2)) + POS_W'(dx_s2);
	assign yp  = $signed(POS_W'(cy_s2)) + POS_W'(dy_s2);

	always_comb begin
		if (xp[POS_W-1]) begin
			xc = '0;
		end else if (xp > $signed(POS_W'(wm1))) begin
			xc = wm1[COL_W-1:0];
		end else begin
			xc = xp[COL_W-1:0];
		end
		if (yp[POS_W-1]) begin
			yc = '0;
		end else if (yp > $signed(POS_W'(hm1))) begin
			yc = hm1[ROW_W-1:0];
		end else begin
			yc = yp[ROW_W-1:0];
		end
	end

	// stage 4: linear source address
	assign off_sum = PROD_W'(yc_s3) * PROD_W'(cfg.width) + PROD_W'(xc_s3);

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s1   <= cx;
			cy_s1   <= cy;
			a_s1    <= a;
			b_s1    <= b;
			c_s1    <= c;
			done_s1 <= done;
			last_s1 <= rest == '0;

			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
			dx_s2   <= dx;
			dy_s2   <= dy;
			pix_s2  <= pix_sum[ADDR_W-1:0];
			done_s2 <= done_s1;
			last_s2 <= last_s1;

			xc_s3   <= xc;
			yc_s3   <= yc;
			pix_s3  <= pix_s2;
			done_s3 <= done_s2;
			last_s3 <= last_s2;

			off_s4  <= off_sum[ADDR_W-1:0];
			pix_s4  <= pix_s3;
			done_s4 <= done_s3;
			last_s4 <= last_s3;
		end
	end

	// output beat
	assign results.valid         = valid_s4;
	assign results.pixel_index   = pix_s4;
	assign results.source_offset = off_s4;
	assign results.last_of_run   = last_s4;
	assign results.frame_done    = done_s4;

endmodule

/* hw/rtl/bump_offset_generator_core.sv */
// ----------------------------------------------------------------------------
// bump_offset_generator_core
// turns a raster height map into displaced, clamped light map addresses
// ----------------------------------------------------------------------------
// samples: one 8-bit height per beat in raster order; results: pixel index,
// displaced source offset, last_of_run on the final result of a sample and
// frame_done on the frame's final pixel. results follow the order of the samples.
// frame width, frame height and slope gain sit on the apb port at 0x0, 0x4
// and 0x8; write them only while the block is idle.
// a sample is taken every cycle unless samples is held off. row 0 yields no
// result unless it is the last row, other rows one per sample, and the last
// row up to three, so there the output port (one result per cycle) sets the
// pace and the job queue fills until samples is held off. the first result
// of a sample passes the line buffer read and front stage register, the job
// queue and the slope/clamp/address pipeline registers to the output register.
// reset returns the position to the frame start and loads the default
// registers (320 x 240, gain 2); the line buffer needs no clearing.
// when results is stalled the whole back end holds, the queue absorbs up to
// four samples, then samples.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bump_offset_generator_core import bog_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	bog_in_if.sink             samples,
	bog_out_if.source          results,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t cfg;
	job_t push_job;
	job_t head;
	logic push;
	logic q_full;
	logic pop;
	logic q_empty;

	assign pready = 1'b1;

	// configuration registers
	bog_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// intake, line buffer and classification
	bog_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.samples  (samples),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	// decoupling queue
	bog_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	// result expansion and address pipeline
	bog_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.head    (head),
		.empty   (q_empty),
		.pop     (pop),
		.results (results)
	);

endmodule

/* tb/bump_offset_generator_core_tb.sv */
// ----------------------------------------------------------------------------
// bump_offset_generator_core_tb
// self-checking bench for the bump offset generator core
// ----------------------------------------------------------------------------
// height beats go in through the samples channel and each is run through a
// local model of the line buffer, position and slope/clamp arithmetic. the
// model queues the offsets that each beat should produce, and a monitor
// compares every offset beat leaving the core with the oldest queued entry.
// frame size and gain change over the apb port only with the core drained.
// directed frames cover reset values, a frame shrunk under the current
// position, degenerate and saturated sizes, extreme slopes and gains. random
// frames of small size follow. the sender idles in bursts and the receiver
// stalls on changing patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bump_offset_generator_core_tb import bog_pkg::*; ();

	localparam int CLK_HALF       = 10;
	localparam int LATENCY_CYCLES = 10;
	localparam int STALL_LIMIT    = 4000;
	localparam int RANDOM_BEATS   = 70;

	// register slot that the core does not decode
	localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_IDX_W'(3);

	typedef struct {
		logic [ADDR_W-1:0] pixel_index;
		logic [ADDR_W-1:0] source_offset;
		logic              last_of_run;
		logic              frame_done;
	} offset_t;

	typedef enum {SINK_OPEN, SINK_COIN, SINK_HICCUP, SINK_COMB} sink_mode_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	bog_in_if  samples_if();
	bog_out_if results_if();

	bump_offset_generator_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the core's registers, line buffer and raster position
	logic [DIM_W-1:0]    width_reg;
	logic [DIM_W-1:0]    height_reg;
	logic [GAIN_W-1:0]   gain_reg;
	logic [SAMPLE_W-1:0] row_buf [MAX_WIDTH];
	int                  col_pos;
	int                  row_pos;
	offset_t             pending_offsets[$];
	offset_t             head_offset;

	int                  beats_sent;
	int                  offsets_checked;
	int                  frames_closed;
	int                  reg_writes;
	int                  mismatches;
	int                  quiet_cycles;

	// sender shaping
	bit                  bursty;
	int                  burst_left;
	bit                  smooth_heights;
	logic [SAMPLE_W-1:0] height_base;

	always #(CLK_HALF) clk = ~clk;

	function automatic int active_width();
		if (width_reg == '0) return 1;
		if (width_reg > MAX_WIDTH) return MAX_WIDTH;
		return int'(width_reg);
	endfunction

	function automatic int active_height();
		if (height_reg == '0) return 1;
		if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
		return int'(height_reg);
	endfunction

	function automatic int scaled_slope(logic [SAMPLE_W-1:0] own, logic [SAMPLE_W-1:0] other);
		return (int'(own) - int'(other)) * int'(gain_reg);
	endfunction

	// move the pixel by its slopes, keep it inside the frame, linearize
	function automatic logic [ADDR_W-1:0] landing_addr(int x, int y, int dx, int dy);
		int w;
		int h;
		int xs;
		int ys;
		w = active_width();
		h = active_height();
		xs = x + dx;
		ys = y + dy;
		if (xs < 0) xs = 0;
		if (xs > w - 1) xs = w - 1;
		if (ys < 0) ys = 0;
		if (ys > h - 1) ys = h - 1;
		return ADDR_W'(ys * w + xs);
	endfunction

	// queue the offsets that one accepted height beat resolves
	function automatic void predict_offsets(logic [SAMPLE_W-1:0] h_in);
		int                  w;
		int                  h;
		int                  x;
		int                  y;
		int                  nxt;
		bit                  last_col;
		bit                  last_row;
		logic [SAMPLE_W-1:0] above;
		logic [SAMPLE_W-1:0] left;
		offset_t             o;
		offset_t             run[$];
		w = active_width();
		h = active_height();
		x = col_pos;
		y = row_pos;
		last_col = (x >= w - 1);
		last_row = (y >= h - 1);
		above = row_buf[x % MAX_WIDTH];
		row_buf[x % MAX_WIDTH] = h_in;
		nxt = last_col ? 0 : (x + 1) % MAX_WIDTH;
		o.last_of_run = 1'b0;
		o.frame_done = 1'b0;
		// pixel one row up, its lower neighbour has just arrived
		if (y >= 1) begin
			o.pixel_index = ADDR_W'((y - 1) * w + x);
			o.source_offset = landing_addr(x, y - 1, scaled_slope(above, row_buf[nxt]),
				scaled_slope(above, h_in));
			run.push_back(o);
		end
		// bottom row: previous pixel, no vertical slope
		if (last_row && x >= 1) begin
			left = row_buf[(x - 1) % MAX_WIDTH];
			o.pixel_index = ADDR_W'(y * w + x - 1);
			o.source_offset = landing_addr(x - 1, y, scaled_slope(left, h_in), 0);
			run.push_back(o);
		end
		// frame's final pixel, flat
		if (last_row && last_col) begin
			o.pixel_index = ADDR_W'(y * w + x);
			o.source_offset = landing_addr(x, y, 0, 0);
			o.frame_done = 1'b1;
			run.push_back(o);
		end
		if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
		foreach (run[i]) pending_offsets.push_back(run[i]);
		// advance the raster position
		if (last_col) begin
			col_pos = 0;
			row_pos = last_row ? 0 : y + 1;
		end else begin
			col_pos = x + 1;
		end
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_height();
		int v;
		if (!smooth_heights) return SAMPLE_W'($urandom_range(0, 255));
		v = int'(height_base) + int'($urandom_range(0, 6)) - 3;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		height_base = SAMPLE_W'(v);
		return height_base;
	endfunction

	// apb write: setup then access, shadow copy follows the core
	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_FRAME_WIDTH: width_reg = data[DIM_W-1:0];
			REG_FRAME_HEIGHT: height_reg = data[DIM_W-1:0];
			REG_SLOPE_GAIN: gain_reg = data[GAIN_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// frame setup, optionally with noise above the decoded bits
	task automatic write_frame_cfg(int w, int h, int g, bit junk);
		logic [PDATA_W-1:0] noise;
		noise = junk ? PDATA_W'($urandom) : '0;
		write_reg(REG_FRAME_WIDTH, (noise & ~PDATA_W'(2047)) | PDATA_W'(w));
		write_reg(REG_FRAME_HEIGHT, (noise & ~PDATA_W'(2047)) | PDATA_W'(h));
		write_reg(REG_SLOPE_GAIN, (noise & ~PDATA_W'(15)) | PDATA_W'(g));
	endtask

	// one height beat, with burst gaps ahead of it when enabled
	task automatic send_beat(logic [SAMPLE_W-1:0] h_in);
		int gap;
		@(negedge clk);
		gap = 0;
		if (bursty) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 6);
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
		end
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.height_sample <= h_in;
		@(posedge clk);
		while (!samples_if.ready) @(posedge clk);
		predict_offsets(h_in);
		beats_sent++;
	endtask

	// hold the sender until every queued offset is out, then let the pipe empty
	task automatic drain_offsets();
		@(negedge clk);
		samples_if.valid <= 1'b0;
		while (pending_offsets.size() != 0) @(posedge clk);
		repeat (LATENCY_CYCLES) @(posedge clk);
	endtask

	// reset registers: full first row and a few beats of the second
	task automatic test_reset_defaults();
		bursty = 1'b1;
		smooth_heights = 1'b0;
		repeat (active_width() + 4) send_beat(pick_height());
		drain_offsets();
	endtask

	// shrink the frame so the current position lies on its last row
	task automatic test_shrunken_frame();
		write_reg(REG_FRAME_WIDTH, PDATA_W'(8));
		write_reg(REG_FRAME_HEIGHT, PDATA_W'(2));
		send_beat(8'hFF);
		drain_offsets();
	endtask

	// zero sizes, single column, single row, undecoded register
	task automatic test_degenerate_sizes();
		write_frame_cfg(0, 0, 5, 1'b0);
		send_beat(8'h00);
		send_beat(8'hFF);
		send_beat(8'h80);
		drain_offsets();
		write_reg(REG_SPARE, PDATA_W'($urandom));
		write_frame_cfg(1, 4, 15, 1'b0);
		send_beat(8'h00);
		send_beat(8'hFF);
		send_beat(8'h00);
		send_beat(8'hFF);
		drain_offsets();
		write_frame_cfg(5, 1, 9, 1'b0);
		send_beat(8'hFF);
		send_beat(8'h00);
		send_beat(8'h80);
		send_beat(8'h00);
		send_beat(8'hFF);
		drain_offsets();
	endtask

	// checkerboard of full-scale heights at maximum gain, then zero gain
	task automatic test_extreme_slopes();
		write_frame_cfg(4, 3, 15, 1'b0);
		for (int i = 0; i < 12; i++) send_beat((((i % 4) + (i / 4)) % 2) != 0 ? 8'hFF : 8'h00);
		drain_offsets();
		write_frame_cfg(3, 2, 0, 1'b0);
		for (int i = 0; i < 6; i++) send_beat($urandom_range(0, 1) != 0 ? 8'hFF : 8'h00);
		drain_offsets();
	endtask

	// sender stops mid-frame until the core has nothing left to deliver
	task automatic test_mid_frame_pause();
		write_frame_cfg(6, 4, 3, 1'b0);
		smooth_heights = 1'b1;
		height_base = 8'd128;
		repeat (10) send_beat(pick_height());
		drain_offsets();
		repeat (14) send_beat(pick_height());
		drain_offsets();
	endtask

	// saturated width and height, steep slopes clamp onto the last column and row
	task automatic test_max_sizes();
		smooth_heights = 1'b0;
		write_frame_cfg(2047, 1, 7, 1'b1);
		for (int i = 0; i < 6; i++) send_beat((i % 2) != 0 ? 8'h00 : 8'hFF);
		drain_offsets();
		write_frame_cfg(1, 2047, 15, 1'b0);
		for (int i = 0; i < 8; i++) send_beat((i % 2) != 0 ? 8'h00 : 8'hFF);
		drain_offsets();
	endtask

	// random small frames with random gain, heights and pacing
	task automatic test_random_frames();
		int start;
		int w;
		int h;
		int n;
		start = beats_sent;
		while (beats_sent - start < RANDOM_BEATS) begin
			case ($urandom_range(0, 19))
				0: w = 0;
				1: w = $urandom_range(9, 16);
				default: w = $urandom_range(1, 8);
			endcase
			h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
			write_frame_cfg(w, h, $urandom_range(0, 15), $urandom_range(0, 3) == 0);
			bursty = ($urandom_range(0, 3) != 0);
			smooth_heights = ($urandom_range(0, 1) != 0);
			height_base = SAMPLE_W'($urandom_range(0, 255));
			n = active_width() * active_height();
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 39) == 0) drain_offsets();
				send_beat(pick_height());
			end
			drain_offsets();
		end
	endtask

	// compare one field of an offset beat
	task automatic check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// offset beat monitor
	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready) begin
			if (pending_offsets.size() == 0) begin
				$error("offset beat with nothing expected: pixel_index %0d",
					results_if.pixel_index);
				mismatches++;
			end else begin
				head_offset = pending_offsets.pop_front();
				check_field("pixel_index", head_offset.pixel_index, results_if.pixel_index);
				check_field("source_offset", head_offset.source_offset,
					results_if.source_offset);
				check_field("last_of_run", ADDR_W'(head_offset.last_of_run),
					ADDR_W'(results_if.last_of_run));
				check_field("frame_done", ADDR_W'(head_offset.frame_done),
					ADDR_W'(results_if.frame_done));
				offsets_checked++;
				if (head_offset.frame_done) frames_closed++;
			end
		end
	end

	// receiver back-pressure, pattern picked anew at random intervals
	initial begin : receiver
		sink_mode_t mode;
		int         mode_left;
		int         tick;
		mode = SINK_OPEN;
		mode_left = 0;
		tick = 0;
		results_if.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			tick++;
			case (mode)
				SINK_OPEN: results_if.ready <= 1'b1;
				SINK_COIN: results_if.ready <= ($urandom_range(0, 1) != 0);
				SINK_HICCUP: results_if.ready <= ($urandom_range(0, 7) != 0);
				default: results_if.ready <= (tick % 3 != 0);
			endcase
		end
	end

	// watchdog on cycles without any beat or register access
	always @(posedge clk) begin
		if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready)
			|| (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		samples_if.valid <= 1'b0;
		samples_if.height_sample <= '0;
		width_reg = FRAME_WIDTH_RST;
		height_reg = FRAME_HEIGHT_RST;
		gain_reg = SLOPE_GAIN_RST;
		col_pos = 0;
		row_pos = 0;
		beats_sent = 0;
		offsets_checked = 0;
		frames_closed = 0;
		reg_writes = 0;
		mismatches = 0;
		bursty = 1'b0;
		burst_left = 0;
		smooth_heights = 1'b0;
		height_base = 8'd128;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_shrunken_frame();
		test_degenerate_sizes();
		test_extreme_slopes();
		test_mid_frame_pause();
		test_max_sizes();
		test_random_frames();
		drain_offsets();

		$display("covered %0d height beats, %0d offsets checked, %0d frames closed",
			beats_sent, offsets_checked, frames_closed);
		$display("%0d register writes: zero, saturated and shrunken sizes, gain 0 to 15",
			reg_writes);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
